### rtl/turn_signal_mode_controller_top_assert.svh
// Assertion macros for the turn-signal mode controller.
// Included by the top level; expects clk and arst_n in scope.
`ifndef TURN_SIGNAL_MODE_CONTROLLER_TOP_ASSERT_SVH
`define TURN_SIGNAL_MODE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSMCTL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSMCTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tsmctl_pkg.sv
// Shared types and constants for the turn-signal mode controller.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package tsmctl_pkg;

	// Turn-signal modes as seen on the result channel.
	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_RIGHT  = 2'd1,
		MODE_LEFT   = 2'd2,
		MODE_HAZARD = 2'd3
	} mode_t;

	// Kind of input beat.
	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_TICK   = 1'b1
	} req_type_t;

	localparam int unsigned TIME_W    = 16;
	localparam int unsigned ELAPSED_W = 10;
	localparam int unsigned BTN_W     = 2;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	// Button bit positions.
	localparam int unsigned BTN_LEFT  = 1;
	localparam int unsigned BTN_RIGHT = 0;

	// Modes from which a press loads the raw buttons directly (off, hazard).
	localparam logic [3:0] MODE_RELOAD_MASK = 4'b1001;

	localparam logic [TIME_W-1:0] RESET_PERIOD = 16'd830;
	localparam logic [TIME_W-1:0] RESET_HOLD   = 16'd70;

	// Register index, taken from paddr[2].
	localparam logic REG_BLINK_PERIOD  = 1'b0;
	localparam logic REG_DEBOUNCE_HOLD = 1'b1;

	typedef struct packed {
		req_type_t            req_type;
		logic [BTN_W-1:0]     buttons;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] blink_period_ms;
		logic [TIME_W-1:0] debounce_hold_ms;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [TIME_W-1:0] blink_phase;
	} result_t;

endpackage

### rtl/tsmctl_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on tsmctl_pkg.
`timescale 1ns / 1ps

// Input channel: button samples and time ticks.
interface tsmctl_in_if;
	logic                                valid;
	logic                                ready;
	tsmctl_pkg::req_type_t               req_type;
	logic [tsmctl_pkg::BTN_W-1:0]        buttons;
	logic [tsmctl_pkg::ELAPSED_W-1:0]    elapsed_ms;

	modport source (output valid, output req_type, output buttons, output elapsed_ms,
		input ready);
	modport sink (input valid, input req_type, input buttons, input elapsed_ms,
		output ready);
endinterface

// Result channel: mode and blink phase after each input beat.
interface tsmctl_out_if;
	logic                              valid;
	logic                              ready;
	tsmctl_pkg::mode_t                 mode;
	logic [tsmctl_pkg::TIME_W-1:0]     blink_phase;

	modport source (output valid, output mode, output blink_phase, input ready);
	modport sink (input valid, input mode, input blink_phase, output ready);
endinterface

### rtl/tsmctl_regs.sv
// APB-style configuration registers: blink period and debounce hold time.
// Depends on tsmctl_pkg.
`timescale 1ns / 1ps

module tsmctl_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsmctl_pkg::PADDR_W-1:0]   paddr,
	input  logic [tsmctl_pkg::PDATA_W-1:0]   pwdata,
	output logic [tsmctl_pkg::PDATA_W-1:0]   prdata,
	output logic                             pready,
	output tsmctl_pkg::cfg_t                 cfg
);

	logic [tsmctl_pkg::TIME_W-1:0] period_q;
	logic [tsmctl_pkg::TIME_W-1:0] hold_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tsmctl_pkg::RESET_PERIOD;
			hold_q   <= tsmctl_pkg::RESET_HOLD;
		end else if (wr_en) begin
			unique case (paddr[2])
				tsmctl_pkg::REG_BLINK_PERIOD:  period_q <= pwdata[tsmctl_pkg::TIME_W-1:0];
				tsmctl_pkg::REG_DEBOUNCE_HOLD: hold_q   <= pwdata[tsmctl_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			tsmctl_pkg::REG_BLINK_PERIOD:  prdata[tsmctl_pkg::TIME_W-1:0] = period_q;
			tsmctl_pkg::REG_DEBOUNCE_HOLD: prdata[tsmctl_pkg::TIME_W-1:0] = hold_q;
			default: ;
		endcase
	end

	assign cfg.blink_period_ms  = period_q;
	assign cfg.debounce_hold_ms = hold_q;

endmodule

### rtl/tsmctl_core.sv
// Controller state (mode, debounced buttons, phase, hold timers) and its update.
// Depends on tsmctl_pkg.
`timescale 1ns / 1ps

module tsmctl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tsmctl_pkg::item_t   item,
	input  tsmctl_pkg::cfg_t    cfg,
	output tsmctl_pkg::mode_t   cur_mode,
	output tsmctl_pkg::result_t nxt
);

	localparam int unsigned TW = tsmctl_pkg::TIME_W;

	tsmctl_pkg::mode_t             mode_q;
	logic [tsmctl_pkg::BTN_W-1:0]  prev_db_q;
	logic [TW-1:0]                 phase_q;
	logic [TW-1:0]                 left_q;
	logic [TW-1:0]                 right_q;

	tsmctl_pkg::mode_t             mode_d;
	logic [tsmctl_pkg::BTN_W-1:0]  prev_db_d;
	logic [TW-1:0]                 phase_d;
	logic [TW-1:0]                 left_d;
	logic [TW-1:0]                 right_d;

	logic [tsmctl_pkg::BTN_W-1:0]  raw;
	logic [tsmctl_pkg::BTN_W-1:0]  db;
	logic [tsmctl_pkg::BTN_W-1:0]  rises;
	logic [TW-1:0]                 left_s;
	logic [TW-1:0]                 right_s;
	tsmctl_pkg::mode_t             mode_s;
	logic                          reload;
	logic [TW-1:0]                 dt;
	logic [TW-1:0]                 sum;

	assign raw = item.buttons;
	assign dt  = {{(TW - tsmctl_pkg::ELAPSED_W){1'b0}}, item.elapsed_ms};

	// Sample path: reload hold timers, stretch the buttons, detect rising edges.
	always_comb begin
		left_s  = raw[tsmctl_pkg::BTN_LEFT]  ? cfg.debounce_hold_ms : left_q;
		right_s = raw[tsmctl_pkg::BTN_RIGHT] ? cfg.debounce_hold_ms : right_q;
		db      = raw;
		db[tsmctl_pkg::BTN_LEFT]  = raw[tsmctl_pkg::BTN_LEFT]  | (left_s  != '0);
		db[tsmctl_pkg::BTN_RIGHT] = raw[tsmctl_pkg::BTN_RIGHT] | (right_s != '0);
		rises  = db & ~prev_db_q;
		reload = tsmctl_pkg::MODE_RELOAD_MASK[mode_q];
		mode_s = mode_q;
		if (rises != '0) begin
			priority if (reload) begin
				mode_s = tsmctl_pkg::mode_t'(raw);
			end else if (raw == tsmctl_pkg::MODE_HAZARD) begin
				mode_s = tsmctl_pkg::MODE_HAZARD;
			end else if (raw != mode_q) begin
				mode_s = tsmctl_pkg::MODE_OFF;
			end else begin
				// A press of the same side keeps the current mode.
				mode_s = mode_q;
			end
		end
	end

	// Tick path: advance the phase with one wrap by the period.
	assign sum = phase_q + dt;

	// Next-state selection by beat kind.
	always_comb begin
		mode_d    = mode_q;
		prev_db_d = prev_db_q;
		phase_d   = phase_q;
		left_d    = left_q;
		right_d   = right_q;
		unique case (item.req_type)
			tsmctl_pkg::REQ_SAMPLE: begin
				mode_d    = mode_s;
				prev_db_d = db;
				left_d    = left_s;
				right_d   = right_s;
				if (mode_s != mode_q) begin
					phase_d = '0;
				end
			end
			tsmctl_pkg::REQ_TICK: begin
				phase_d = (sum >= cfg.blink_period_ms) ? sum - cfg.blink_period_ms : sum;
				left_d  = (left_q  > dt) ? left_q  - dt : '0;
				right_d = (right_q > dt) ? right_q - dt : '0;
			end
			default: ;
		endcase
	end

	// State registers advance once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tsmctl_pkg::MODE_OFF;
			prev_db_q <= '0;
			phase_q   <= '0;
			left_q    <= '0;
			right_q   <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			prev_db_q <= prev_db_d;
			phase_q   <= phase_d;
			left_q    <= left_d;
			right_q   <= right_d;
		end
	end

	assign cur_mode        = mode_q;
	assign nxt.mode        = mode_d;
	assign nxt.blink_phase = phase_d;

endmodule

### rtl/turn_signal_mode_controller_top.sv
// Turn-signal mode controller: accepts one button sample or time tick per clock and
// returns one result beat (mode and blink phase after the update) for each. A beat
// is held in the input register, where the state update is computed, and the
// result then sits in the output register until it is taken; the sustained rate
// is one beat per cycle while results are taken, set by the single state update path
// between these two registers. While a finished result waits, the input side takes
// one more beat into an empty input register, then stalls until the result is taken.
// Configuration is an APB-style port: blink period at 0x0, debounce hold at 0x4.
// Depends on tsmctl_pkg, the channel interfaces, tsmctl_regs and tsmctl_core.
`timescale 1ns / 1ps

`include "turn_signal_mode_controller_top_assert.svh"

module turn_signal_mode_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	tsmctl_in_if.sink                        req,
	tsmctl_out_if.source                     rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsmctl_pkg::PADDR_W-1:0]   paddr,
	input  logic [tsmctl_pkg::PDATA_W-1:0]   pwdata,
	output logic [tsmctl_pkg::PDATA_W-1:0]   prdata,
	output logic                             pready
);

	tsmctl_pkg::cfg_t    cfg;
	tsmctl_pkg::item_t   item_s1;
	logic                valid_s1;
	logic                advance;
	tsmctl_pkg::mode_t   cur_mode;
	tsmctl_pkg::result_t nxt;
	tsmctl_pkg::result_t res_q;
	logic                res_valid_q;

	// Configuration registers.
	tsmctl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the input stage moves when the result register is free or drains.
	assign advance   = valid_s1 & (~res_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready & req.valid) begin
			item_s1.req_type   <= req.req_type;
			item_s1.buttons    <= req.buttons;
			item_s1.elapsed_ms <= req.elapsed_ms;
		end
	end

	// State update.
	tsmctl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.cur_mode (cur_mode),
		.nxt      (nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= nxt;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.mode        = res_q.mode;
	assign rsp.blink_phase = res_q.blink_phase;

	// Checks on the stage handoff and the mode rules.
	`TSMCTL_ASSERT_NOW(a_ready_when_empty, !valid_s1, req.ready,
		"input stage empty but not ready")
	`TSMCTL_ASSERT_NEXT(a_result_after_step, advance, rsp.valid,
		"processed beat left no result")
	`TSMCTL_ASSERT_NEXT(a_tick_keeps_mode, advance && item_s1.req_type == tsmctl_pkg::REQ_TICK,
		rsp.mode == $past(cur_mode), "tick changed the mode")
	`TSMCTL_ASSERT_NEXT(a_mode_change_clears_phase, advance && nxt.mode != cur_mode,
		rsp.blink_phase == '0, "mode change did not clear the phase")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the turn-signal mode controller: a directed table, then
// random phases under several register settings, scored by a predictor or typed row values.
// Depends on tsmctl_pkg, the channel interfaces and turn_signal_mode_controller_top.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned WATCHDOG_LIMIT  = 3000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned IDLE_PCT        = 32;

	typedef enum bit {
		ROW_BEAT,
		ROW_CFG
	} row_kind_t;

	// One line of the directed plan: either an input beat or a register write.
	typedef struct {
		row_kind_t           kind;
		logic                reg_sel;
		logic [15:0]         value;
		tsmctl_pkg::item_t   beat;
		bit                  typed;
		tsmctl_pkg::result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tsmctl_pkg::PADDR_W-1:0] paddr;
	logic [tsmctl_pkg::PDATA_W-1:0] pwdata;
	logic [tsmctl_pkg::PDATA_W-1:0] prdata;
	logic pready;

	tsmctl_in_if  req_if();
	tsmctl_out_if rsp_if();

	turn_signal_mode_controller_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state and its copy of the registers.
	logic [15:0]       cfg_period;
	logic [15:0]       cfg_hold;
	tsmctl_pkg::mode_t lamp_mode;
	logic [1:0]        db_prev;
	logic [15:0]       phase;
	logic [15:0]       hold_left;
	logic [15:0]       hold_right;

	tsmctl_pkg::result_t pending_lamp_q[$];
	int unsigned         mismatch_count;
	int unsigned         idle_streak;
	bit                  idle_en;
	bit                  hold_off_go;
	logic [1:0]          last_buttons;

	// Expectation attached to the beat currently offered, for typed table rows.
	bit                  beat_typed;
	tsmctl_pkg::result_t beat_want;

	// Clock generation.
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// Reset and known values on every input from time zero.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.req_type = tsmctl_pkg::REQ_SAMPLE;
		req_if.buttons = '0;
		req_if.elapsed_ms = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Advance the lamp state by one beat and return the mode and phase after it.
	function automatic tsmctl_pkg::result_t advance_lamp(input tsmctl_pkg::item_t it);
		logic [1:0]          raw;
		logic [1:0]          db;
		logic [1:0]          rises;
		tsmctl_pkg::mode_t   was;
		tsmctl_pkg::result_t r;
		if (it.req_type == tsmctl_pkg::REQ_SAMPLE) begin
			raw = it.buttons;
			was = lamp_mode;
			db = raw;
			if (raw[tsmctl_pkg::BTN_LEFT]) hold_left = cfg_hold;
			if (raw[tsmctl_pkg::BTN_RIGHT]) hold_right = cfg_hold;
			if (hold_left != 16'd0) db[tsmctl_pkg::BTN_LEFT] = 1'b1;
			if (hold_right != 16'd0) db[tsmctl_pkg::BTN_RIGHT] = 1'b1;
			rises = db & ~db_prev;
			db_prev = db;
			// A new press reloads from off or hazard, else it combines with the side.
			if (rises != 2'd0) begin
				if (tsmctl_pkg::MODE_RELOAD_MASK[lamp_mode]) begin
					lamp_mode = tsmctl_pkg::mode_t'(raw);
				end else if (raw == tsmctl_pkg::MODE_HAZARD) begin
					lamp_mode = tsmctl_pkg::MODE_HAZARD;
				end else if (lamp_mode != raw) begin
					lamp_mode = tsmctl_pkg::MODE_OFF;
				end
			end
			if (lamp_mode != was) phase = '0;
		end else begin
			// The sum wraps at 16 bits before the compare with the period.
			phase = phase + 16'(it.elapsed_ms);
			if (phase >= cfg_period) phase = phase - cfg_period;
			hold_left = (hold_left > 16'(it.elapsed_ms)) ? hold_left - 16'(it.elapsed_ms) : '0;
			hold_right = (hold_right > 16'(it.elapsed_ms)) ?
				hold_right - 16'(it.elapsed_ms) : '0;
		end
		r.mode = lamp_mode;
		r.blink_phase = phase;
		return r;
	endfunction

	// Accepted input beats are predicted; accepted result beats are scored.
	always @(posedge clk) begin : scoreboard
		tsmctl_pkg::item_t   seen;
		tsmctl_pkg::result_t pred;
		tsmctl_pkg::result_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				seen = {req_if.req_type, req_if.buttons, req_if.elapsed_ms};
				pred = advance_lamp(seen);
				pending_lamp_q.push_back(beat_typed ? beat_want : pred);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_lamp_q.size() == 0) begin
					report_mismatch("result beat with nothing pending",
						32'(rsp_if.blink_phase), 0);
				end else begin
					want = pending_lamp_q.pop_front();
					if (rsp_if.mode !== want.mode)
						report_mismatch("mode", 32'(rsp_if.mode), 32'(want.mode));
					if (rsp_if.blink_phase !== want.blink_phase)
						report_mismatch("blink_phase", 32'(rsp_if.blink_phase),
							32'(want.blink_phase));
				end
			end
			// Watchdog: too long without any beat moving on either channel.
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_streak = 0;
			end else begin
				idle_streak++;
				if (idle_streak >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no beat accepted for %0d cycles", idle_streak);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// Result side: random back-pressure, plus one long hold-off when requested.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				rsp_if.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_go = 1'b0;
			end
			rsp_if.ready = (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) ? 1'b0 : 1'b1;
		end
	end

	// Offer one input beat, with random gaps first, and return after it is accepted.
	task automatic send_beat(input tsmctl_pkg::item_t it, input bit typed,
			input tsmctl_pkg::result_t want);
		while (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
			req_if.valid = 1'b0;
			req_if.req_type = tsmctl_pkg::req_type_t'($urandom_range(0, 1));
			req_if.buttons = 2'($urandom_range(0, 3));
			req_if.elapsed_ms = 10'($urandom_range(0, 1023));
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.req_type = it.req_type;
		req_if.buttons = it.buttons;
		req_if.elapsed_ms = it.elapsed_ms;
		beat_typed = typed;
		beat_want = want;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every pending result has come back.
	task automatic drain;
		req_if.valid = 1'b0;
		beat_typed = 1'b0;
		while (pending_lamp_q.size() != 0) @(negedge clk);
	endtask

	// Register write followed by a read-back; called at a falling edge with the block idle.
	task automatic cfg_write(input logic reg_sel, input logic [15:0] value);
		logic [tsmctl_pkg::PADDR_W-1:0] addr;
		addr = '0;
		addr[2] = reg_sel;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== {16'd0, value}) report_mismatch("register read-back", prdata, 32'(value));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (reg_sel == tsmctl_pkg::REG_BLINK_PERIOD) cfg_period = value;
		else cfg_hold = value;
	endtask

	function automatic plan_row_t beat_row(input tsmctl_pkg::req_type_t t,
			input logic [1:0] b, input logic [9:0] e, input bit typed,
			input tsmctl_pkg::mode_t m, input logic [15:0] p);
		plan_row_t r;
		r.kind = ROW_BEAT;
		r.reg_sel = tsmctl_pkg::REG_BLINK_PERIOD;
		r.value = '0;
		r.beat.req_type = t;
		r.beat.buttons = b;
		r.beat.elapsed_ms = e;
		r.typed = typed;
		r.want.mode = m;
		r.want.blink_phase = p;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic reg_sel, input logic [15:0] value);
		plan_row_t r;
		r = beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b0, tsmctl_pkg::MODE_OFF, 16'd0);
		r.kind = ROW_CFG;
		r.reg_sel = reg_sel;
		r.value = value;
		return r;
	endfunction

	// Random beat: samples mostly repeat the last buttons so presses are held and released.
	function automatic tsmctl_pkg::item_t random_beat(input int unsigned tick_pct,
			input bit big_steps);
		tsmctl_pkg::item_t it;
		int unsigned       pick;
		it.req_type = ($urandom_range(0, 99) < tick_pct) ? tsmctl_pkg::REQ_TICK :
			tsmctl_pkg::REQ_SAMPLE;
		it.buttons = 2'($urandom_range(0, 3));
		it.elapsed_ms = 10'($urandom_range(0, 1023));
		if (it.req_type == tsmctl_pkg::REQ_SAMPLE) begin
			if ($urandom_range(0, 99) < 55) it.buttons = last_buttons;
			last_buttons = it.buttons;
		end else if (big_steps) begin
			if ($urandom_range(0, 1) == 1) it.elapsed_ms = 10'd1023;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) it.elapsed_ms = 10'($urandom_range(0, 40));
			else if (pick < 70) it.elapsed_ms = 10'd0;
			else if (pick < 80) it.elapsed_ms = 10'd1023;
		end
		return it;
	endfunction

	// One random phase under a fresh register setting.
	task automatic run_phase(input logic [15:0] period, input logic [15:0] hold,
			input int unsigned count, input int unsigned tick_pct, input bit big_steps,
			input bit quiet, input bit squeeze);
		tsmctl_pkg::result_t none;
		none = '0;
		drain();
		cfg_write(tsmctl_pkg::REG_BLINK_PERIOD, period);
		cfg_write(tsmctl_pkg::REG_DEBOUNCE_HOLD, hold);
		idle_en = !quiet;
		if (squeeze) hold_off_go = 1'b1;
		repeat (count) send_beat(random_beat(tick_pct, big_steps), 1'b0, none);
		idle_en = 1'b1;
	endtask

	initial begin : stimulus
		plan_row_t plan[$];
		plan_row_t row;
		cfg_period = tsmctl_pkg::RESET_PERIOD;
		cfg_hold = tsmctl_pkg::RESET_HOLD;
		lamp_mode = tsmctl_pkg::MODE_OFF;
		db_prev = '0;
		phase = '0;
		hold_left = '0;
		hold_right = '0;
		mismatch_count = 0;
		idle_streak = 0;
		idle_en = 1'b1;
		hold_off_go = 1'b0;
		last_buttons = '0;
		beat_typed = 1'b0;
		beat_want = '0;

		// Reset values first, then each mode transition, unused fields carrying noise.
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd3, 10'd0, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd1023, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd2, 10'd0, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd3, 10'd1023, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd193));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd1, 10'd0, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd3, 10'd0, 1'b1,
			tsmctl_pkg::MODE_HAZARD, 16'd0));
		// Released buttons stay high until the hold timers run out.
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b1,
			tsmctl_pkg::MODE_HAZARD, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd69, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd1, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd1, 10'd0, 1'b1,
			tsmctl_pkg::MODE_RIGHT, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd100, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		// Same side again keeps the mode and the phase; both buttons give hazard.
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd1, 10'd0, 1'b0,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd3, 10'd0, 1'b1,
			tsmctl_pkg::MODE_HAZARD, 16'd0));
		// Zero hold time: the pressed bit still counts for its own sample.
		plan.push_back(cfg_row(tsmctl_pkg::REG_DEBOUNCE_HOLD, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd1023, 1'b1,
			tsmctl_pkg::MODE_HAZARD, 16'd193));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b1,
			tsmctl_pkg::MODE_HAZARD, 16'd193));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd2, 10'd0, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd2, 10'd0, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd0));
		// Shortest period subtracts once; a zero period never pulls the phase back.
		plan.push_back(cfg_row(tsmctl_pkg::REG_BLINK_PERIOD, 16'd1));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd5, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd4));
		plan.push_back(cfg_row(tsmctl_pkg::REG_BLINK_PERIOD, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd1023, 1'b1,
			tsmctl_pkg::MODE_LEFT, 16'd1027));
		plan.push_back(cfg_row(tsmctl_pkg::REG_BLINK_PERIOD, 16'hFFFF));
		plan.push_back(cfg_row(tsmctl_pkg::REG_DEBOUNCE_HOLD, 16'hFFFF));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd1, 10'd0, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd0));
		plan.push_back(beat_row(tsmctl_pkg::REQ_TICK, 2'd0, 10'd1023, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd1023));
		plan.push_back(beat_row(tsmctl_pkg::REQ_SAMPLE, 2'd0, 10'd0, 1'b1,
			tsmctl_pkg::MODE_OFF, 16'd1023));

		wait (arst_n === 1'b1);
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_CFG) begin
				drain();
				cfg_write(row.reg_sel, row.value);
			end else begin
				send_beat(row.beat, row.typed, row.want);
			end
		end

		// Random phases: reset setting with a long result hold-off, the extremes, a
		// tick-heavy phase that wraps the phase, an idle-free stretch, then random settings.
		run_phase(tsmctl_pkg::RESET_PERIOD, tsmctl_pkg::RESET_HOLD, 250, 50, 1'b0, 1'b0,
			1'b1);
		run_phase(16'd1, 16'd0, 150, 50, 1'b0, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 120, 50, 1'b0, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'd20, 220, 97, 1'b1, 1'b0, 1'b0);
		run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 400)), 300, 50, 1'b0,
			1'b1, 1'b0);
		repeat (3) begin
			run_phase(($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535)) :
				16'($urandom_range(1, 2000)), 16'($urandom_range(0, 400)), 140, 50, 1'b0,
				1'b0, 1'b0);
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
